// ----- hw/rtl/cle_pkg.sv -----
// Shared types and constants of the console line editor.
package cle_pkg;

  // Byte codes of the console protocol.
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_UP     = 8'h41;
  localparam logic [7:0] CH_DOWN   = 8'h42;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_UC_LO  = 8'h41;
  localparam logic [7:0] CH_UC_HI  = 8'h5A;
  localparam logic [7:0] CASE_DIFF = 8'd32;

  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_CHAR = 2'd1,
    KIND_END  = 2'd2,
    KIND_SAVE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ESC_NONE    = 2'd0,
    ESC_SEEN    = 2'd1,
    ESC_BRACKET = 2'd2
  } esc_e;

  // Source of the byte of an emitted result.
  typedef enum logic [2:0] {
    SRC_IN   = 3'd0,
    SRC_BS   = 3'd1,
    SRC_SP   = 3'd2,
    SRC_RD   = 3'd3,
    SRC_LOW  = 3'd4,
    SRC_CUR  = 3'd5,
    SRC_ONE  = 3'd6,
    SRC_ZERO = 3'd7
  } src_e;

  // Address of the history length read port.
  typedef enum logic [1:0] {
    LEN_CAND   = 2'd0,
    LEN_RIDX   = 2'd1,
    LEN_NEWEST = 2'd2
  } len_src_e;

  typedef struct packed {
    logic     take_in;
    logic     esc_we;
    esc_e     esc_val;
    logic     line_push;
    logic     cursor_dec;
    logic     i_clr;
    logic     i_inc;
    logic     lf_lower;
    logic     lf_end;
    logic     rec_step;
    logic     rec_fall;
    logic     len_ld;
    len_src_e len_src;
    logic     load_wr;
    logic     load_end;
    logic     rd_en;
    logic     rd_newest;
    logic     copy_wr;
    logic     save_commit;
    logic     comp_clr;
    logic     emit;
    kind_e    emit_kind;
    src_e     emit_src;
    logic     flush;
  } cmd_t;

  typedef struct packed {
    logic req_save;
    esc_e esc;
    logic is_lbrack;
    logic is_esc;
    logic is_erase;
    logic is_store;
    logic is_lf;
    logic is_up;
    logic is_down;
    logic cursor_zero;
    logic cursor_full;
    logic i_lt_cursor;
    logic i_lt_len;
    logic i_lt_comp;
    logic len_zero;
    logic len_eq_comp;
    logic comp_zero;
    logic rd_eq_line;
    logic emit_ok;
    logic flush_ok;
  } sts_t;

endpackage

// ----- hw/rtl/cle_ifs.sv -----
// Valid/ready channel interfaces for requests and results.
interface cle_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source(output valid, output req_type, output rx_byte, input ready);
  modport sink(input valid, input req_type, input rx_byte, output ready);
endinterface

interface cle_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       last;

  modport source(output valid, output out_kind, output out_byte, output last, input ready);
  modport sink(input valid, input out_kind, input out_byte, input last, output ready);
endinterface

// ----- hw/rtl/cle_dp.sv -----
// Datapath: line buffer, history store, editor registers and result staging.
module cle_dp #(
  parameter int LINE_LEN   = 16,
  parameter int HIST_DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_type_i,
  input  logic [7:0]       rx_byte_i,
  input  cle_pkg::cmd_t    cmd_i,
  output cle_pkg::sts_t    sts_o,
  cle_out_if.source        res_o
);

  localparam int CW        = $clog2(LINE_LEN + 1);
  localparam int IW        = $clog2(LINE_LEN);
  localparam int HW        = $clog2(HIST_DEPTH);
  localparam int MEM_DEPTH = HIST_DEPTH * (2 ** IW);

  logic [HW-1:0] head_q, ridx_q;
  logic          rv_q;
  logic          req_q;
  logic [7:0]    byte_q;
  cle_pkg::esc_e esc_q;
  logic [CW-1:0] cursor_q, comp_q, i_q, len_q;
  logic [CW-1:0] hlen_q [HIST_DEPTH];
  logic [7:0]    line_q [LINE_LEN];
  logic [7:0]    hist_mem [MEM_DEPTH];
  logic [7:0]    rd_q;

  logic          pend_v_q;
  logic [1:0]    pend_kind_q;
  logic [7:0]    pend_byte_q;
  logic          out_v_q;
  logic [1:0]    out_kind_q;
  logic [7:0]    out_byte_q;
  logic          out_last_q;

  logic [HW-1:0] newest, cand, fall, len_addr;
  logic          older;
  logic [7:0]    line_i, line_low, emit_byte;
  logic          out_free;

  function automatic logic [HW-1:0] hprev(input logic [HW-1:0] x);
    hprev = (x == '0) ? HW'(HIST_DEPTH - 1) : x - HW'(1);
  endfunction

  function automatic logic [HW-1:0] hnext(input logic [HW-1:0] x);
    hnext = (x == HW'(HIST_DEPTH - 1)) ? '0 : x + HW'(1);
  endfunction

  function automatic logic [7:0] lower(input logic [7:0] c);
    lower = (c >= cle_pkg::CH_UC_LO && c <= cle_pkg::CH_UC_HI) ? c + cle_pkg::CASE_DIFF : c;
  endfunction

  assign newest   = hprev(head_q);
  assign older    = (byte_q == cle_pkg::CH_UP);
  assign cand     = rv_q ? (older ? hprev(ridx_q) : hnext(ridx_q))
                         : (older ? newest : head_q);
  assign fall     = older ? newest : '0;
  assign line_i   = line_q[i_q[IW-1:0]];
  assign line_low = lower(line_i);
  assign out_free = !out_v_q || res_o.ready;

  always_comb begin
    case (cmd_i.len_src)
      cle_pkg::LEN_CAND:   len_addr = cand;
      cle_pkg::LEN_NEWEST: len_addr = newest;
      default:             len_addr = ridx_q;
    endcase
  end

  always_comb begin
    case (cmd_i.emit_src)
      cle_pkg::SRC_IN:  emit_byte = byte_q;
      cle_pkg::SRC_BS:  emit_byte = cle_pkg::CH_BS;
      cle_pkg::SRC_SP:  emit_byte = cle_pkg::CH_SP;
      cle_pkg::SRC_RD:  emit_byte = rd_q;
      cle_pkg::SRC_LOW: emit_byte = line_low;
      cle_pkg::SRC_CUR: emit_byte = 8'(cursor_q);
      cle_pkg::SRC_ONE: emit_byte = 8'd1;
      default:          emit_byte = 8'd0;
    endcase
  end

  always_comb begin
    sts_o.req_save    = req_q;
    sts_o.esc         = esc_q;
    sts_o.is_lbrack   = (byte_q == cle_pkg::CH_LBRACK);
    sts_o.is_esc      = (byte_q == cle_pkg::CH_ESC);
    sts_o.is_erase    = (byte_q == cle_pkg::CH_BS) || (byte_q == cle_pkg::CH_DEL);
    sts_o.is_store    = (byte_q > 8'd31 && byte_q < cle_pkg::CH_DEL) ||
                        (byte_q == cle_pkg::CH_CR);
    sts_o.is_lf       = (byte_q == cle_pkg::CH_LF);
    sts_o.is_up       = (byte_q == cle_pkg::CH_UP);
    sts_o.is_down     = (byte_q == cle_pkg::CH_DOWN);
    sts_o.cursor_zero = (cursor_q == '0);
    sts_o.cursor_full = (cursor_q == CW'(LINE_LEN));
    sts_o.i_lt_cursor = (i_q < cursor_q);
    sts_o.i_lt_len    = (i_q < len_q);
    sts_o.i_lt_comp   = (i_q < comp_q);
    sts_o.len_zero    = (len_q == '0);
    sts_o.len_eq_comp = (len_q == comp_q);
    sts_o.comp_zero   = (comp_q == '0);
    sts_o.rd_eq_line  = (rd_q == line_i);
    sts_o.emit_ok     = !pend_v_q || out_free;
    sts_o.flush_ok    = !pend_v_q || out_free;
  end

  // Editor control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q    <= cle_pkg::ESC_NONE;
      cursor_q <= '0;
      comp_q   <= '0;
      i_q      <= '0;
      head_q   <= '0;
      ridx_q   <= '0;
      rv_q     <= 1'b0;
      len_q    <= '0;
      req_q    <= 1'b0;
      for (int k = 0; k < HIST_DEPTH; k++) hlen_q[k] <= '0;
    end else begin
      if (cmd_i.take_in) req_q <= req_type_i;
      if (cmd_i.esc_we) esc_q <= cmd_i.esc_val;
      if (cmd_i.line_push) cursor_q <= cursor_q + CW'(1);
      if (cmd_i.cursor_dec) cursor_q <= cursor_q - CW'(1);
      if (cmd_i.load_end) cursor_q <= len_q;
      if (cmd_i.lf_end) begin
        comp_q   <= cursor_q;
        cursor_q <= '0;
      end
      if (cmd_i.comp_clr) comp_q <= '0;
      if (cmd_i.i_clr) i_q <= '0;
      else if (cmd_i.i_inc) i_q <= i_q + CW'(1);
      if (cmd_i.len_ld) len_q <= hlen_q[len_addr];
      if (cmd_i.rec_step) begin
        ridx_q <= cand;
        rv_q   <= 1'b1;
      end
      if (cmd_i.rec_fall) ridx_q <= fall;
      if (cmd_i.save_commit) begin
        hlen_q[head_q] <= comp_q;
        head_q         <= hnext(head_q);
        rv_q           <= 1'b0;
      end
    end
  end

  // Payload storage: captured byte, line buffer, history memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) byte_q <= rx_byte_i;
    if (cmd_i.line_push) line_q[cursor_q[IW-1:0]] <= byte_q;
    if (cmd_i.lf_lower) line_q[i_q[IW-1:0]] <= line_low;
    if (cmd_i.load_wr) line_q[i_q[IW-1:0]] <= rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.copy_wr) hist_mem[{head_q, i_q[IW-1:0]}] <= line_i;
    if (cmd_i.rd_en) rd_q <= hist_mem[{(cmd_i.rd_newest ? newest : ridx_q), i_q[IW-1:0]}];
  end

  // Result staging: one pending result ahead of the output register, so the
  // final result of an item can be marked once the item is finished.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if ((cmd_i.emit || cmd_i.flush) && pend_v_q) out_v_q <= 1'b1;
      else if (res_o.ready) out_v_q <= 1'b0;
      if (cmd_i.emit) pend_v_q <= 1'b1;
      else if (cmd_i.flush) pend_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((cmd_i.emit || cmd_i.flush) && pend_v_q) begin
      out_kind_q <= pend_kind_q;
      out_byte_q <= pend_byte_q;
      out_last_q <= cmd_i.flush;
    end
    if (cmd_i.emit) begin
      pend_kind_q <= cmd_i.emit_kind;
      pend_byte_q <= emit_byte;
    end
  end

  assign res_o.valid    = out_v_q;
  assign res_o.out_kind = out_kind_q;
  assign res_o.out_byte = out_byte_q;
  assign res_o.last     = out_last_q;

endmodule

// ----- hw/rtl/cle_ctrl.sv -----
// Sequencer that steps the datapath through the work of one request.
module cle_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cle_pkg::sts_t sts_i,
  output cle_pkg::cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_BS1, ST_SP, ST_BS2, ST_ERASE_CHK,
    ST_REC_STEP, ST_REC_FIX, ST_REC_LEN, ST_LOAD_RD, ST_LOAD_WR, ST_LF_CH,
    ST_SAVE_LEN, ST_SAVE_CHK, ST_CMP_RD, ST_CMP_EQ, ST_COPY, ST_SAVE_END,
    ST_FLUSH
  } state_e;

  state_e state_q, state_d;
  logic   erase_all_q, erase_all_d;
  logic   save_ok_q, save_ok_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    erase_all_d = erase_all_q;
    save_ok_d   = save_ok_q;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          state_d       = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts_i.req_save) begin
          state_d = ST_SAVE_LEN;
        end else if (sts_i.esc == cle_pkg::ESC_SEEN && sts_i.is_lbrack) begin
          cmd_o.esc_we  = 1'b1;
          cmd_o.esc_val = cle_pkg::ESC_BRACKET;
          state_d       = ST_FLUSH;
        end else if (sts_i.esc == cle_pkg::ESC_BRACKET) begin
          cmd_o.esc_we  = 1'b1;
          cmd_o.esc_val = cle_pkg::ESC_NONE;
          erase_all_d   = 1'b1;
          state_d       = ST_ERASE_CHK;
        end else if (sts_i.is_esc) begin
          cmd_o.esc_we  = 1'b1;
          cmd_o.esc_val = cle_pkg::ESC_SEEN;
          state_d       = ST_FLUSH;
        end else if (sts_i.is_erase) begin
          cmd_o.esc_we  = 1'b1;
          cmd_o.esc_val = cle_pkg::ESC_NONE;
          erase_all_d   = 1'b0;
          state_d       = sts_i.cursor_zero ? ST_FLUSH : ST_BS1;
        end else if ((sts_i.is_store || sts_i.is_lf) && !sts_i.cursor_full) begin
          if (sts_i.emit_ok) begin
            cmd_o.esc_we    = 1'b1;
            cmd_o.esc_val   = cle_pkg::ESC_NONE;
            cmd_o.emit      = 1'b1;
            cmd_o.emit_kind = cle_pkg::KIND_ECHO;
            cmd_o.emit_src  = cle_pkg::SRC_IN;
            cmd_o.line_push = sts_i.is_store;
            cmd_o.i_clr     = 1'b1;
            state_d         = sts_i.is_lf ? ST_LF_CH : ST_FLUSH;
          end
        end else begin
          cmd_o.esc_we  = 1'b1;
          cmd_o.esc_val = cle_pkg::ESC_NONE;
          cmd_o.i_clr   = 1'b1;
          state_d       = sts_i.is_lf ? ST_LF_CH : ST_FLUSH;
        end
      end
      ST_BS1: begin
        if (sts_i.emit_ok) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = cle_pkg::KIND_ECHO;
          cmd_o.emit_src  = cle_pkg::SRC_BS;
          state_d         = ST_SP;
        end
      end
      ST_SP: begin
        if (sts_i.emit_ok) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = cle_pkg::KIND_ECHO;
          cmd_o.emit_src  = cle_pkg::SRC_SP;
          state_d         = ST_BS2;
        end
      end
      ST_BS2: begin
        if (sts_i.emit_ok) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_kind  = cle_pkg::KIND_ECHO;
          cmd_o.emit_src   = cle_pkg::SRC_BS;
          cmd_o.cursor_dec = 1'b1;
          state_d          = erase_all_q ? ST_ERASE_CHK : ST_FLUSH;
        end
      end
      ST_ERASE_CHK: begin
        if (!sts_i.cursor_zero) state_d = ST_BS1;
        else if (sts_i.is_up || sts_i.is_down) state_d = ST_REC_STEP;
        else state_d = ST_FLUSH;
      end
      ST_REC_STEP: begin
        cmd_o.rec_step = 1'b1;
        cmd_o.len_ld   = 1'b1;
        cmd_o.len_src  = cle_pkg::LEN_CAND;
        state_d        = ST_REC_FIX;
      end
      ST_REC_FIX: begin
        if (sts_i.len_zero) begin
          cmd_o.rec_fall = 1'b1;
          state_d        = ST_REC_LEN;
        end else begin
          cmd_o.i_clr = 1'b1;
          state_d     = ST_LOAD_RD;
        end
      end
      ST_REC_LEN: begin
        cmd_o.len_ld  = 1'b1;
        cmd_o.len_src = cle_pkg::LEN_RIDX;
        cmd_o.i_clr   = 1'b1;
        state_d       = ST_LOAD_RD;
      end
      ST_LOAD_RD: begin
        if (sts_i.i_lt_len) begin
          cmd_o.rd_en = 1'b1;
          state_d     = ST_LOAD_WR;
        end else begin
          cmd_o.load_end = 1'b1;
          state_d        = ST_FLUSH;
        end
      end
      ST_LOAD_WR: begin
        if (sts_i.emit_ok) begin
          cmd_o.load_wr   = 1'b1;
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = cle_pkg::KIND_ECHO;
          cmd_o.emit_src  = cle_pkg::SRC_RD;
          cmd_o.i_inc     = 1'b1;
          state_d         = ST_LOAD_RD;
        end
      end
      ST_LF_CH: begin
        if (sts_i.emit_ok) begin
          cmd_o.emit = 1'b1;
          if (sts_i.i_lt_cursor) begin
            cmd_o.lf_lower  = 1'b1;
            cmd_o.emit_kind = cle_pkg::KIND_CHAR;
            cmd_o.emit_src  = cle_pkg::SRC_LOW;
            cmd_o.i_inc     = 1'b1;
          end else begin
            cmd_o.emit_kind = cle_pkg::KIND_END;
            cmd_o.emit_src  = cle_pkg::SRC_CUR;
            cmd_o.lf_end    = 1'b1;
            state_d         = ST_FLUSH;
          end
        end
      end
      ST_SAVE_LEN: begin
        cmd_o.len_ld  = 1'b1;
        cmd_o.len_src = cle_pkg::LEN_NEWEST;
        state_d       = ST_SAVE_CHK;
      end
      ST_SAVE_CHK: begin
        cmd_o.i_clr = 1'b1;
        if (sts_i.comp_zero) begin
          save_ok_d = 1'b0;
          state_d   = ST_SAVE_END;
        end else if (!sts_i.len_eq_comp) begin
          state_d = ST_COPY;
        end else begin
          state_d = ST_CMP_RD;
        end
      end
      ST_CMP_RD: begin
        if (sts_i.i_lt_comp) begin
          cmd_o.rd_en     = 1'b1;
          cmd_o.rd_newest = 1'b1;
          state_d         = ST_CMP_EQ;
        end else begin
          save_ok_d = 1'b0;
          state_d   = ST_SAVE_END;
        end
      end
      ST_CMP_EQ: begin
        if (sts_i.rd_eq_line) begin
          cmd_o.i_inc = 1'b1;
          state_d     = ST_CMP_RD;
        end else begin
          cmd_o.i_clr = 1'b1;
          state_d     = ST_COPY;
        end
      end
      ST_COPY: begin
        if (sts_i.i_lt_comp) begin
          cmd_o.copy_wr = 1'b1;
          cmd_o.i_inc   = 1'b1;
        end else begin
          cmd_o.save_commit = 1'b1;
          save_ok_d         = 1'b1;
          state_d           = ST_SAVE_END;
        end
      end
      ST_SAVE_END: begin
        if (sts_i.emit_ok) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = cle_pkg::KIND_SAVE;
          cmd_o.emit_src  = save_ok_q ? cle_pkg::SRC_ONE : cle_pkg::SRC_ZERO;
          cmd_o.comp_clr  = 1'b1;
          state_d         = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (sts_i.flush_ok) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      erase_all_q <= 1'b0;
      save_ok_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      erase_all_q <= erase_all_d;
      save_ok_q   <= save_ok_d;
    end
  end

endmodule

// ----- hw/rtl/console_line_editor.sv -----
// Console line editor with command history: top level.
//
//  channel   dir  modport  payload                      transfer when
//  item_i    in   sink     req_type, rx_byte            valid && ready
//  res_o     out  source   out_kind, out_byte, last     valid && ready
//
// One request is worked at a time; ready is high only while the sequencer
// waits for work. A request passes accept, dispatch and flush; a plain
// echo goes out during dispatch. On top come: backspace, space, backspace
// per erased character, plus one check per character and a final check
// when an escape erases the whole line; for a recall a step, a length
// check and, on a fallback, a reload, then a registered history read and a
// write per recalled character and an end step; one step per completed
// line character and one for the line end; for a save a load, a check, a
// read and compare and a copy per character, a commit and the result.
// Reset clears all control state and every history length, so history is
// empty at once; no clearing pass runs. Results go out through an output
// register behind a one-entry pending stage; the sequencer holds while
// both are full, so a stalled sink never loses or repeats a transfer.
module console_line_editor #(
  parameter int LINE_LEN   = 16,
  parameter int HIST_DEPTH = 4
) (
  input logic       clk_i,
  input logic       rst_ni,
  cle_in_if.sink    item_i,
  cle_out_if.source res_o
);

  cle_pkg::cmd_t cmd;
  cle_pkg::sts_t sts;
  logic          ready;

  // Only accepted requests advance the sequencer.
  assign item_i.ready = ready;

  cle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Line buffer, history and result staging live in the datapath.
  cle_dp #(
    .LINE_LEN   (LINE_LEN),
    .HIST_DEPTH (HIST_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_type_i (item_i.req_type),
    .rx_byte_i  (item_i.rx_byte),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_o      (res_o)
  );

endmodule

// ----- verif/tb.sv -----
// Testbench for the console line editor: predicted echo, line and history results.
module tb;
  import cle_pkg::*;

  localparam int LINE_LEN     = 16;
  localparam int HIST_DEPTH   = 4;
  localparam int MAX_RESULTS  = 64;
  localparam int RANDOM_ITEMS = 240;
  localparam int TAIL_CYCLES  = 200;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } editor_result_t;

  // Shadow of the editor state plus the results it still owes.
  class editor_scoreboard;
    logic [7:0]     line_buf [LINE_LEN];
    int unsigned    cursor;
    esc_e           esc_state;
    int unsigned    done_len;
    logic [7:0]     hist_buf [HIST_DEPTH][LINE_LEN];
    int unsigned    hist_len [HIST_DEPTH];
    int unsigned    head;
    int unsigned    recall_pos;
    bit             recall_on;
    editor_result_t item_q[$];
    editor_result_t expected_q[$];
    int unsigned    failures;

    function new();
      cursor     = 0;
      esc_state  = ESC_NONE;
      done_len   = 0;
      head       = 0;
      recall_pos = 0;
      recall_on  = 1'b0;
      failures   = 0;
      foreach (hist_len[i]) hist_len[i] = 0;
    endfunction

    function int unsigned hist_prev(int unsigned i);
      return (i > 0) ? i - 1 : HIST_DEPTH - 1;
    endfunction

    function int unsigned hist_next(int unsigned i);
      return (i + 1 >= HIST_DEPTH) ? 0 : i + 1;
    endfunction

    function void emit(kind_e kind, logic [7:0] data);
      editor_result_t r;
      r.kind = kind;
      r.data = data;
      r.last = 1'b0;
      if (item_q.size() < MAX_RESULTS) item_q.push_back(r);
    endfunction

    function void erase_char();
      if (cursor > 0) begin
        emit(KIND_ECHO, CH_BS);
        emit(KIND_ECHO, CH_SP);
        emit(KIND_ECHO, CH_BS);
        cursor--;
      end
    endfunction

    function void load_entry();
      int unsigned n;
      int unsigned i;
      n = hist_len[recall_pos];
      for (i = 0; i < n; i++) begin
        line_buf[i] = hist_buf[recall_pos][i];
        emit(KIND_ECHO, line_buf[i]);
      end
      cursor = n;
    endfunction

    function void take_byte(logic [7:0] c);
      logic [7:0]  ch;
      int unsigned i;
      if (esc_state == ESC_SEEN && c == CH_LBRACK) begin
        esc_state = ESC_BRACKET;
        return;
      end
      if (esc_state == ESC_BRACKET) begin
        while (cursor > 0) erase_char();
        if (c == CH_UP) begin
          recall_pos = recall_on ? hist_prev(recall_pos) : hist_prev(head);
          recall_on  = 1'b1;
          if (hist_len[recall_pos] == 0) recall_pos = hist_prev(head);
          load_entry();
        end else if (c == CH_DOWN) begin
          recall_pos = recall_on ? hist_next(recall_pos) : head;
          recall_on  = 1'b1;
          if (hist_len[recall_pos] == 0) recall_pos = 0;
          load_entry();
        end
        esc_state = ESC_NONE;
        return;
      end
      esc_state = ESC_NONE;
      if (c == CH_ESC) begin
        esc_state = ESC_SEEN;
      end else if (c == CH_BS || c == CH_DEL) begin
        erase_char();
      end else if (cursor < LINE_LEN &&
                   ((c >= CH_SP && c < CH_DEL) || c == CH_CR || c == CH_LF)) begin
        if (c != CH_LF) begin
          line_buf[cursor] = c;
          cursor++;
        end
        emit(KIND_ECHO, c);
      end
      if (c == CH_LF) begin
        for (i = 0; i < cursor; i++) begin
          ch = line_buf[i];
          if (ch >= CH_UC_LO && ch <= CH_UC_HI) ch = ch + CASE_DIFF;
          line_buf[i] = ch;
          emit(KIND_CHAR, ch);
        end
        emit(KIND_END, 8'(cursor));
        done_len = cursor;
        cursor   = 0;
      end
    endfunction

    // Predict one accepted request; report whether it did anything at all.
    function bit note_request(logic req, logic [7:0] rx);
      esc_e           esc_was;
      int unsigned    newest;
      int unsigned    i;
      bit             same;
      bit             saved;
      editor_result_t r;
      esc_was = esc_state;
      item_q.delete();
      if (req) begin
        saved  = 1'b0;
        newest = hist_prev(head);
        if (done_len != 0) begin
          same = (hist_len[newest] == done_len);
          if (same)
            for (i = 0; i < done_len; i++)
              if (hist_buf[newest][i] != line_buf[i]) same = 1'b0;
          if (!same) begin
            for (i = 0; i < done_len; i++) hist_buf[head][i] = line_buf[i];
            hist_len[head] = done_len;
            recall_on      = 1'b0;
            head           = hist_next(head);
            saved          = 1'b1;
          end
        end
        emit(KIND_SAVE, {7'd0, saved});
        done_len = 0;
      end else begin
        take_byte(rx);
      end
      if (item_q.size() > 0) begin
        r = item_q.pop_back();
        r.last = 1'b1;
        item_q.push_back(r);
      end
      foreach (item_q[i]) expected_q.push_back(item_q[i]);
      return item_q.size() > 0 || esc_was != ESC_NONE || esc_state != ESC_NONE;
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] data, logic last);
      editor_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, got kind %0d byte %02h last %0b",
                 $time, kind, data, last);
        failures++;
        return;
      end
      want = expected_q.pop_front();
      if (want.kind !== kind || want.data !== data || want.last !== last) begin
        $display("%0t: mismatch: expected kind %0d byte %02h last %0b, got %0d %02h %0b",
                 $time, want.kind, want.data, want.last, kind, data, last);
        failures++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  cle_in_if  item_if ();
  cle_out_if res_if ();

  console_line_editor #(
    .LINE_LEN  (LINE_LEN),
    .HIST_DEPTH(HIST_DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .item_i(item_if),
    .res_o (res_if)
  );

  editor_scoreboard editor_sb = new();

  int          send_idle_pct   = 26;
  int          recv_idle_pct   = 72;
  int unsigned effective_items = 0;
  int unsigned cycle_count     = 0;

  always #5 clk_i = ~clk_i;

  // Receiver: redraw ready every cycle from the current idle ratio.
  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Check every result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      editor_sb.check_result(res_if.out_kind, res_if.out_byte, res_if.last);
  end

  // Watchdog: end the run as failed once the cycle count reaches the limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [7:0] pick_printable();
    // Lean on uppercase so lowercasing on line end gets exercised.
    if ($urandom_range(0, 3) == 0) return CH_UC_LO + 8'($urandom_range(0, 25));
    return 8'($urandom_range(CH_SP, CH_DEL - 1));
  endfunction

  // Offer one request and hold it until the editor takes it. Valid is only
  // dropped when an idle gap is drawn, so back-to-back transfers keep it high.
  task automatic send_item(input logic req, input logic [7:0] data);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    item_if.valid    <= 1'b1;
    item_if.req_type <= req;
    item_if.rx_byte  <= data;
    do @(posedge clk_i); while (!item_if.ready);
    if (editor_sb.note_request(req, data)) effective_items++;
  endtask

  // Stop offering requests until every predicted result has been seen.
  task automatic wait_for_results();
    item_if.valid <= 1'b0;
    do @(posedge clk_i); while (editor_sb.expected_q.size() != 0);
  endtask

  task automatic send_escape(input logic [7:0] final_byte);
    send_item(1'b0, CH_ESC);
    send_item(1'b0, CH_LBRACK);
    send_item(1'b0, final_byte);
  endtask

  // One random burst: mostly well-formed lines and history walks, the rest
  // noise and broken escape sequences.
  task automatic random_burst();
    int unsigned pick;
    int unsigned n;
    int unsigned k;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      // Type a line, now and then long enough to fill the buffer.
      n = ($urandom_range(0, 6) == 0) ? $urandom_range(LINE_LEN - 3, LINE_LEN + 2)
                                      : $urandom_range(0, 8);
      for (k = 0; k < n; k++) begin
        case ($urandom_range(0, 19))
          0:       send_item(1'b0, $urandom_range(0, 1) ? CH_BS : CH_DEL);
          1:       send_item(1'b0, CH_CR);
          default: send_item(1'b0, pick_printable());
        endcase
      end
      send_item(1'b0, CH_LF);
      if ($urandom_range(0, 9) < 8) send_item(1'b1, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) == 0) send_item(1'b1, 8'($urandom_range(0, 255)));
    end else if (pick < 65) begin
      // Walk the history, now and then touch up the recalled line, mostly commit it.
      n = $urandom_range(1, 5);
      for (k = 0; k < n; k++) send_escape($urandom_range(0, 2) == 0 ? CH_DOWN : CH_UP);
      if ($urandom_range(0, 2) == 0) send_item(1'b0, pick_printable());
      if ($urandom_range(0, 2) == 0) send_item(1'b0, CH_BS);
      if ($urandom_range(0, 3) != 0) begin
        send_item(1'b0, CH_LF);
        send_item(1'b1, 8'($urandom_range(0, 255)));
      end
    end else if (pick < 85) begin
      n = $urandom_range(1, 4);
      for (k = 0; k < n; k++) send_item(1'b0, 8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          send_item(1'b0, CH_ESC);
          send_item(1'b0, 8'($urandom_range(0, 255)));
        end
        1:       send_escape(8'($urandom_range(0, 255)));
        default: begin
          send_item(1'b0, CH_ESC);
          send_escape($urandom_range(0, 1) ? CH_UP : CH_DOWN);
        end
      endcase
    end
  endtask

  initial begin
    int phase;
    rst_ni           = 1'b0;
    item_if.valid    = 1'b0;
    item_if.req_type = 1'b0;
    item_if.rx_byte  = 8'h00;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty history: save is skipped, backspace and recall do nothing.
    send_item(1'b1, 8'h00);
    send_item(1'b0, CH_BS);
    send_escape(CH_UP);
    // Printable extremes, both case bounds, CR, then erase the CR.
    send_item(1'b0, CH_SP);
    send_item(1'b0, CH_DEL - 8'd1);
    send_item(1'b0, CH_UC_LO);
    send_item(1'b0, CH_UC_HI);
    send_item(1'b0, CH_CR);
    send_item(1'b0, CH_DEL);
    send_item(1'b0, CH_LF);
    // Save, then a repeated save that finds nothing left to store.
    send_item(1'b1, 8'hFF);
    send_item(1'b1, 8'h00);
    // Recall the entry and commit it again: a duplicate, so skipped.
    send_escape(CH_UP);
    send_item(1'b0, CH_LF);
    send_item(1'b1, 8'h00);
    // Recall newer, then an unknown final that only erases.
    send_escape(CH_DOWN);
    send_escape(CH_DOWN + 8'd1);
    // ESC followed by a plain byte, and ESC restarted by a second ESC.
    send_item(1'b0, CH_ESC);
    send_item(1'b0, CH_UC_LO + CASE_DIFF);
    send_item(1'b0, CH_ESC);
    send_escape(CH_DOWN);
    // Bytes with the top bit set and low control bytes are dropped.
    send_item(1'b0, 8'h80);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h00);
    send_item(1'b0, CH_LF);
    wait_for_results();

    // Random part in three idle regimes; drain between them.
    effective_items = 0;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 26; recv_idle_pct = 72; end
        1:       begin send_idle_pct = 72; recv_idle_pct = 26; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      while (effective_items < (phase + 1) * RANDOM_ITEMS / 3) random_burst();
      wait_for_results();
    end

    // Give the editor time to finish any request that owes no result.
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (editor_sb.failures == 0 && editor_sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
